[rtl/iou_greedy_box_tracker_defines.svh]
// Assertion macros for the IOU box tracker.
// Used by the top level only; needs clk and rst in scope.
`ifndef IOU_GREEDY_BOX_TRACKER_DEFINES_SVH
`define IOU_GREEDY_BOX_TRACKER_DEFINES_SVH
// implication checked on every edge outside reset
`define IOU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IOU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/iou_pkg.sv]
// Shared types and constants of the IOU box tracker.
// No dependencies.
package iou_pkg;
  localparam logic [1:0] KIND_NEW      = 2'd0;
  localparam logic [1:0] KIND_AVERAGED = 2'd1;
  localparam logic [1:0] KIND_REPLACED = 2'd2;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic        box_valid;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_w;
    logic [15:0] out_h;
    logic [1:0]  match_kind;
    logic        store_full;
    logic        frame_last;
  } out_item_t;
endpackage

[rtl/iou_if.sv]
// Valid/ready channel carrying one payload.
// Payload type is a type parameter, usually from iou_pkg.
interface iou_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/iou_greedy_box_tracker.sv]
// Top level of the greedy IOU box tracker.
// Depends on iou_pkg, iou_if and iou_greedy_box_tracker_defines.svh.
//
// Usage: detected boxes arrive one per transfer on in_ch (x, y, w, h,
// box_valid, frame_end). Each transfer with box_valid set gives one
// transfer on out_ch: the tracked box, how it matched (new, averaged,
// replaced), whether the track store was full, and frame_last.
// A transfer with box_valid clear gives no result but may end a frame.
// Timing: in_ch is ready only in idle. After a transfer with box_valid set the
// block walks the previous frame's tracks through a shared overlap unit: an
// unclaimed track goes through load, area/union, two cross products and
// compare; a claimed one is skipped. Then the block decides, registers the
// result and returns to idle, so it takes no new box until the walk and the
// decision are done. The track walk sets the rate. The result waits in an
// output register while the next box is worked on; if the receiver still
// stalls when that box is decided, the block holds and takes no new box.
// Reset clears counts, claim bits and the handshake; the box stores hold
// stale data that is never read before it is written.
`include "iou_greedy_box_tracker_defines.svh"
module iou_greedy_box_tracker #(
  parameter int MAX_TRACKS = 16,
  parameter int COORD_BITS = 16
) (
  input logic clk,
  input logic rst,
  iou_if.sink   in_ch,
  iou_if.source out_ch
);
  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam int EW = COORD_BITS + 1;
  localparam int AW = 2 * COORD_BITS + 2;
  localparam int PW = 2 * AW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TRACKS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AREA = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DEC  = 3'd5;

  typedef logic [4*COORD_BITS-1:0] box_word_t;

  logic [2:0] state;
  box_word_t prev_mem [2][MAX_TRACKS];
  logic bank;
  logic [MAX_TRACKS-1:0] claimed;
  logic [CW-1:0] prev_count, curr_count, idx;
  logic [COORD_BITS-1:0] bx, by, bw, bh;
  logic fend;
  box_word_t trk;
  logic found;
  logic [IW-1:0] best;
  logic [AW-1:0] bi, bu, ti, tu;
  logic [PW-1:0] p1, p2;
  box_word_t best_box;
  logic [COORD_BITS-1:0] tx, ty, tw, th;
  iou_pkg::out_item_t res;
  logic out_valid;
  logic dec_go;

  assign {tx, ty, tw, th} = trk;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = res;
  // the output register is free or empties at this edge
  assign dec_go = !out_valid || out_ch.ready;

  // overlap of stored track and current box
  logic [EW-1:0] l, t, r, b, iw, ih;
  logic [AW-1:0] inter, uni;
  always_comb begin
    l = (tx > bx) ? EW'(tx) : EW'(bx);
    t = (ty > by) ? EW'(ty) : EW'(by);
    r = ((EW'(tx) + EW'(tw)) < (EW'(bx) + EW'(bw))) ? EW'(tx) + EW'(tw)
                                                    : EW'(bx) + EW'(bw);
    b = ((EW'(ty) + EW'(th)) < (EW'(by) + EW'(bh))) ? EW'(ty) + EW'(th)
                                                    : EW'(by) + EW'(bh);
    iw = (r > l) ? r - l : '0;
    ih = (b > t) ? b - t : '0;
    inter = AW'(iw) * AW'(ih);
    uni = AW'(tw) * AW'(th) + AW'(bw) * AW'(bh) - inter;
  end

  logic [IW-1:0] idx_lo;
  assign idx_lo = idx[IW-1:0];
  logic [AW+3:0] i10, u3, i2;
  assign i10 = (AW+4)'(bi) * 10;
  assign u3  = (AW+4)'(bu) * 3;
  assign i2  = (AW+4)'(bi) * 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank <= 1'b0;
      claimed <= '0;
      prev_count <= '0;
      curr_count <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            bx <= in_ch.data.x[COORD_BITS-1:0];
            by <= in_ch.data.y[COORD_BITS-1:0];
            bw <= in_ch.data.w[COORD_BITS-1:0];
            bh <= in_ch.data.h[COORD_BITS-1:0];
            fend <= in_ch.data.frame_end;
            idx <= '0;
            found <= 1'b0;
            bi <= '0;
            bu <= AW'(1);
            if (in_ch.data.box_valid) begin
              state <= S_AREA;
            end else if (in_ch.data.frame_end) begin
              bank <= ~bank;
              claimed <= '0;
              prev_count <= curr_count;
              curr_count <= '0;
            end
          end
        end
        S_AREA: begin
          // skip claimed tracks, stop past the last one
          if (idx >= prev_count) begin
            state <= S_DEC;
          end else if (claimed[idx_lo]) begin
            idx <= idx + 1'b1;
          end else begin
            trk <= prev_mem[bank][idx_lo];
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (uni == '0) begin
            ti <= '0;
            tu <= AW'(1);
          end else begin
            ti <= inter;
            tu <= uni;
          end
          state <= S_MUL2;
        end
        S_MUL2: begin
          p1 <= ti * bu;
          p2 <= bi * tu;
          state <= S_CMP;
        end
        S_CMP: begin
          if (!found || p1 > p2) begin
            found <= 1'b1;
            best <= idx_lo;
            bi <= ti;
            bu <= tu;
            best_box <= trk;
          end
          idx <= idx + 1'b1;
          state <= S_AREA;
        end
        S_DEC: begin
          logic [COORD_BITS-1:0] rx, ry, rw, rh;
          logic [1:0] kind;
          rx = bx; ry = by; rw = bw; rh = bh;
          kind = iou_pkg::KIND_NEW;
          if (found && i10 > u3) begin
            if (dec_go && !fend) claimed[best] <= 1'b1;
            if (i2 < (AW+4)'(bu)) begin
              rx = COORD_BITS'((EW'(best_box[4*COORD_BITS-1 -: COORD_BITS]) + EW'(bx)) >> 1);
              ry = COORD_BITS'((EW'(best_box[3*COORD_BITS-1 -: COORD_BITS]) + EW'(by)) >> 1);
              rw = COORD_BITS'((EW'(best_box[2*COORD_BITS-1 -: COORD_BITS]) + EW'(bw)) >> 1);
              rh = COORD_BITS'((EW'(best_box[COORD_BITS-1 -: COORD_BITS]) + EW'(bh)) >> 1);
              kind = iou_pkg::KIND_AVERAGED;
            end else begin
              kind = iou_pkg::KIND_REPLACED;
            end
          end
          // hold the decision while the previous result is still waiting
          if (dec_go) begin
            res.out_x <= 16'(rx);
            res.out_y <= 16'(ry);
            res.out_w <= 16'(rw);
            res.out_h <= 16'(rh);
            res.match_kind <= kind;
            res.frame_last <= fend;
            res.store_full <= (curr_count >= MAX_CNT);
            if (fend) begin
              bank <= ~bank;
              claimed <= '0;
              prev_count <= (curr_count >= MAX_CNT) ? MAX_CNT : curr_count + 1'b1;
              curr_count <= '0;
            end else if (curr_count < MAX_CNT) begin
              curr_count <= curr_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DEC && dec_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  function automatic box_word_t box_avg(box_word_t a, box_word_t c);
    box_word_t o;
    for (int k = 0; k < 4; k++) begin
      o[k*COORD_BITS +: COORD_BITS] = COORD_BITS'(
        (EW'(a[k*COORD_BITS +: COORD_BITS]) + EW'(c[k*COORD_BITS +: COORD_BITS])) >> 1);
    end
    return o;
  endfunction

  // current-frame store: the bank not being read
  always_ff @(posedge clk) begin
    if (state == S_DEC && dec_go && curr_count < MAX_CNT) begin
      prev_mem[~bank][curr_count[IW-1:0]] <= {
        (found && i10 > u3 && i2 < (AW+4)'(bu))
          ? box_avg(best_box, {bx, by, bw, bh}) : {bx, by, bw, bh}};
    end
  end

  `IOU_ASSERT_NXT(a_dec_hold, state == S_DEC && !dec_go, state == S_DEC, "decision lost")
  `IOU_ASSERT_IMP(a_count_bound, 1'b1, curr_count <= MAX_CNT && prev_count <= MAX_CNT, "count")
  `IOU_ASSERT_NXT(a_hold_stall, out_valid && !out_ch.ready, out_valid && $stable(res), "dropped")
endmodule

[verif/iou_tracker_predictor.sv]
// Behavioral predictor of the greedy IOU box tracker: track stores, claim bits,
// exact integer IOU comparison. Depends on iou_pkg.
package iou_tracker_predictor_pkg;

  localparam int NTRK = 16;

  typedef struct {
    logic [15:0] x, y, w, h;
  } trk_box_t;

  class track_table;
    trk_box_t    prev_trk[NTRK];
    bit          claimed[NTRK];
    int          prev_n;
    trk_box_t    curr_trk[NTRK];
    int          curr_n;

    function void clear();
      prev_n = 0;
      curr_n = 0;
      foreach (claimed[i]) claimed[i] = 1'b0;
    endfunction

    // intersection and union areas, union forced to 1 when empty
    function void areas(trk_box_t p, trk_box_t q, output logic [63:0] ia,
                        output logic [63:0] ua);
      logic [17:0] l, t, r1, r2, b1, b2, r, b, iw, ih;
      l  = (p.x > q.x) ? 18'(p.x) : 18'(q.x);
      t  = (p.y > q.y) ? 18'(p.y) : 18'(q.y);
      r1 = 18'(p.x) + 18'(p.w);
      r2 = 18'(q.x) + 18'(q.w);
      b1 = 18'(p.y) + 18'(p.h);
      b2 = 18'(q.y) + 18'(q.h);
      r  = (r1 < r2) ? r1 : r2;
      b  = (b1 < b2) ? b1 : b2;
      iw = (r > l) ? r - l : '0;
      ih = (b > t) ? b - t : '0;
      ia = 64'(iw) * 64'(ih);
      ua = 64'(p.w) * 64'(p.h) + 64'(q.w) * 64'(q.h) - ia;
      if (ua == '0) begin
        ia = '0;
        ua = 64'd1;
      end
    endfunction

    // returns 1 when a result is produced
    function bit track(iou_pkg::in_item_t it, output iou_pkg::out_item_t res);
      trk_box_t bx, o;
      logic [63:0] ia, ua, bi, bu;
      logic [127:0] lhs, rhs;
      int best;
      bit found;
      logic [1:0] kind;
      bit produced;
      bx.x = it.x; bx.y = it.y; bx.w = it.w; bx.h = it.h;
      produced = 1'b0;
      res = '0;
      if (it.box_valid) begin
        found = 1'b0;
        best = 0;
        bi = '0;
        bu = 64'd1;
        for (int i = 0; i < prev_n; i++) begin
          if (!claimed[i]) begin
            areas(prev_trk[i], bx, ia, ua);
            lhs = 128'(ia) * 128'(bu);
            rhs = 128'(bi) * 128'(ua);
            if (!found || lhs > rhs) begin
              found = 1'b1;
              best = i;
              bi = ia;
              bu = ua;
            end
          end
        end
        o = bx;
        kind = iou_pkg::KIND_NEW;
        if (found && 68'(bi) * 10 > 68'(bu) * 3) begin
          claimed[best] = 1'b1;
          if (65'(bi) * 2 < 65'(bu)) begin
            o.x = 16'((17'(prev_trk[best].x) + 17'(bx.x)) >> 1);
            o.y = 16'((17'(prev_trk[best].y) + 17'(bx.y)) >> 1);
            o.w = 16'((17'(prev_trk[best].w) + 17'(bx.w)) >> 1);
            o.h = 16'((17'(prev_trk[best].h) + 17'(bx.h)) >> 1);
            kind = iou_pkg::KIND_AVERAGED;
          end else begin
            kind = iou_pkg::KIND_REPLACED;
          end
        end
        res.store_full = (curr_n >= NTRK);
        if (curr_n < NTRK) begin
          curr_trk[curr_n] = o;
          curr_n++;
        end
        res.out_x = o.x;
        res.out_y = o.y;
        res.out_w = o.w;
        res.out_h = o.h;
        res.match_kind = kind;
        res.frame_last = it.frame_end;
        produced = 1'b1;
      end
      if (it.frame_end) begin
        prev_trk = curr_trk;
        foreach (claimed[i]) claimed[i] = 1'b0;
        prev_n = curr_n;
        curr_n = 0;
      end
      return produced;
    endfunction
  endclass
endpackage

[verif/iou_greedy_box_tracker_test.sv]
// Testbench for iou_greedy_box_tracker: directed table then random frames,
// checked against track_table. Depends on iou_pkg, iou_if and the predictor.
module iou_greedy_box_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1200;

  typedef struct {
    iou_pkg::in_item_t  item;
    bit                 fixed;
    iou_pkg::out_item_t want;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;

  iou_if #(.payload_t(iou_pkg::in_item_t))  in_ch ();
  iou_if #(.payload_t(iou_pkg::out_item_t)) out_ch ();

  iou_greedy_box_tracker dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  iou_tracker_predictor_pkg::track_table tracks;
  iou_pkg::out_item_t  pending_tracks[$];
  bit                  fixed_q[$];
  iou_pkg::out_item_t  fixed_want_q[$];
  int                  n_errors = 0;
  bit                  stim_done = 0;
  bit                  hold_long = 0;
  iou_tracker_predictor_pkg::trk_box_t recent[$];
  stim_row_t           table_rows[$];

  task automatic report(string what);
    n_errors++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  function automatic iou_pkg::in_item_t mk(int x, int y, int w, int h, bit v, bit fe);
    iou_pkg::in_item_t it;
    it.x = 16'(x); it.y = 16'(y); it.w = 16'(w); it.h = 16'(h);
    it.box_valid = v;
    it.frame_end = fe;
    return it;
  endfunction

  function automatic iou_pkg::out_item_t mk_res(int x, int y, int w, int h, logic [1:0] k,
                                                bit full, bit fl);
    iou_pkg::out_item_t r;
    r.out_x = 16'(x); r.out_y = 16'(y); r.out_w = 16'(w); r.out_h = 16'(h);
    r.match_kind = k;
    r.store_full = full;
    r.frame_last = fl;
    return r;
  endfunction

  function automatic void add_row(iou_pkg::in_item_t it, bit fixed, iou_pkg::out_item_t want);
    stim_row_t row;
    row.item = it;
    row.fixed = fixed;
    row.want = want;
    table_rows = {table_rows, row};
  endfunction

  // transfer one item; queue the expectation at the accepting edge
  task automatic send(iou_pkg::in_item_t it, bit fixed, iou_pkg::out_item_t want);
    iou_pkg::out_item_t r;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (tracks.track(it, r)) begin
      pending_tracks = {pending_tracks, r};
      fixed_q = {fixed_q, fixed};
      fixed_want_q = {fixed_want_q, want};
    end
  endtask

  // random box, often a jitter of a recent one so matches happen
  function automatic iou_pkg::in_item_t rand_box(bit fe);
    iou_pkg::in_item_t it;
    iou_tracker_predictor_pkg::trk_box_t b;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && recent.size() > 0) begin
      b = recent[$urandom_range(0, recent.size() - 1)];
      it = mk(b.x + $urandom_range(0, 20) - 10, b.y + $urandom_range(0, 20) - 10,
              b.w + $urandom_range(0, 30) - 15, b.h + $urandom_range(0, 30) - 15, 1'b1, fe);
    end else if (sel < 8) begin
      it = mk($urandom_range(0, 2000), $urandom_range(0, 2000),
              $urandom_range(1, 300), $urandom_range(1, 300), 1'b1, fe);
    end else begin
      it = mk($urandom, $urandom, $urandom, $urandom, 1'b1, fe);
    end
    return it;
  endfunction

  initial begin
    iou_pkg::out_item_t none;
    iou_pkg::in_item_t  it;
    iou_tracker_predictor_pkg::trk_box_t b;
    int sent, fsize;
    none = '0;
    tracks = new();
    tracks.clear();
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: first frame all new, second frame matches
    add_row(mk(0, 0, 0, 0, 1'b1, 1'b0), 1'b1,
            mk_res(0, 0, 0, 0, iou_pkg::KIND_NEW, 1'b0, 1'b0));
    add_row(mk(65535, 65535, 65535, 65535, 1'b1, 1'b0), 1'b1,
            mk_res(65535, 65535, 65535, 65535, iou_pkg::KIND_NEW, 1'b0, 1'b0));
    add_row(mk(100, 100, 50, 50, 1'b1, 1'b0), 1'b1,
            mk_res(100, 100, 50, 50, iou_pkg::KIND_NEW, 1'b0, 1'b0));
    add_row(mk(1000, 1000, 100, 100, 1'b1, 1'b1), 1'b1,
            mk_res(1000, 1000, 100, 100, iou_pkg::KIND_NEW, 1'b0, 1'b1));
    // identical box replaces; partial overlap averages; empty box stays new
    add_row(mk(100, 100, 50, 50, 1'b1, 1'b0), 1'b1,
            mk_res(100, 100, 50, 50, iou_pkg::KIND_REPLACED, 1'b0, 1'b0));
    add_row(mk(1020, 1020, 100, 100, 1'b1, 1'b0), 1'b0, none);
    add_row(mk(0, 0, 0, 0, 1'b1, 1'b0), 1'b0, none);
    add_row(mk(65535, 65535, 65535, 65535, 1'b1, 1'b0), 1'b0, none);
    add_row(mk(100, 100, 50, 50, 1'b1, 1'b0), 1'b0, none);
    add_row(mk(0, 0, 0, 0, 1'b0, 1'b1), 1'b0, none);
    // empty frame end clears previous tracks
    add_row(mk(0, 0, 0, 0, 1'b0, 1'b1), 1'b0, none);
    add_row(mk(100, 100, 50, 50, 1'b1, 1'b1), 1'b1,
            mk_res(100, 100, 50, 50, iou_pkg::KIND_NEW, 1'b0, 1'b1));
    foreach (table_rows[i]) send(table_rows[i].item, table_rows[i].fixed, table_rows[i].want);
    // store full: 18 boxes in one frame, last two not kept
    for (int i = 0; i < 18; i++)
      send(mk(i * 300, 5000, 100, 100, 1'b1, i == 17), 1'b0, none);
    // next frame: matches against full store, then overflow again
    for (int i = 0; i < 19; i++)
      send(mk(i * 300 + 30 * (i % 3), 5000, 100, 100, 1'b1, i == 18), 1'b0, none);

    sent = 0;
    while (sent < N_RANDOM) begin
      fsize = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
      for (int i = 0; i < fsize; i++) begin
        if ($urandom_range(0, 19) == 0) it = mk($urandom, $urandom, $urandom, $urandom, 1'b0,
                                                 $urandom_range(0, 3) == 0);
        else it = rand_box(i == fsize - 1);
        if (i == fsize - 1) it.frame_end = 1'b1;
        else if ($urandom_range(0, 29) == 0) it.frame_end = 1'b1;
        if (it.box_valid) begin
          b.x = it.x; b.y = it.y; b.w = it.w; b.h = it.h;
          recent = {recent, b};
          if (recent.size() > 24) recent.delete(0);
        end
        if (sent == N_RANDOM / 2) hold_long = 1;
        send(it, 1'b0, none);
        sent++;
      end
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  // receiver: a drawn wait before each result, one long hold-off mid-run
  initial begin
    int wait_n;
    out_ch.ready = 0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      wait_n = $urandom_range(0, 10);
      if (wait_n > 0) begin
        out_ch.ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    iou_pkg::out_item_t exp_r, got;
    bit fx;
    iou_pkg::out_item_t fw;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_tracks.size() == 0) begin
        report("result with no expectation");
      end else begin
        exp_r = pending_tracks[0];
        pending_tracks.delete(0);
        fx = fixed_q[0];
        fixed_q.delete(0);
        fw = fixed_want_q[0];
        fixed_want_q.delete(0);
        if (fx && fw != exp_r) report("directed row disagrees with prediction");
        if (got.out_x != exp_r.out_x) report($sformatf("out_x %0d want %0d", got.out_x, exp_r.out_x));
        if (got.out_y != exp_r.out_y) report($sformatf("out_y %0d want %0d", got.out_y, exp_r.out_y));
        if (got.out_w != exp_r.out_w) report($sformatf("out_w %0d want %0d", got.out_w, exp_r.out_w));
        if (got.out_h != exp_r.out_h) report($sformatf("out_h %0d want %0d", got.out_h, exp_r.out_h));
        if (got.match_kind != exp_r.match_kind)
          report($sformatf("match_kind %0d want %0d", got.match_kind, exp_r.match_kind));
        if (got.store_full != exp_r.store_full)
          report($sformatf("store_full %0b want %0b", got.store_full, exp_r.store_full));
        if (got.frame_last != exp_r.frame_last)
          report($sformatf("frame_last %0b want %0b", got.frame_last, exp_r.frame_last));
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
